// ===== rtl/scc_pkg.sv =====
// Shared types and constants for the sync channel compensation and combining block.
package scc_pkg;

    localparam int SC_W   = 6;
    localparam int SAMP_W = 16;
    localparam int PROD_W = 32;
    localparam int QSHIFT = 15;

    typedef struct packed {
        logic [SC_W-1:0]          subcarrier;
        logic                     first_antenna;
        logic signed [SAMP_W-1:0] pss_rx_re;
        logic signed [SAMP_W-1:0] pss_rx_im;
        logic signed [SAMP_W-1:0] pss_ref_re;
        logic signed [SAMP_W-1:0] pss_ref_im;
        logic signed [SAMP_W-1:0] sss_rx_re;
        logic signed [SAMP_W-1:0] sss_rx_im;
    } t_in_item;

    typedef struct packed {
        logic [SC_W-1:0]          subcarrier_out;
        logic signed [SAMP_W-1:0] comp_re;
        logic signed [SAMP_W-1:0] comp_im;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMP_W-1:0] re;
        logic signed [SAMP_W-1:0] im;
    } t_cplx;

    // Control that travels with each beat through the pipeline.
    typedef struct packed {
        logic                 valid;
        logic [SC_W-1:0]      subcarrier;
        logic                 first_antenna;
    } t_side;

    // Q15 product term wrapped to 16 bits: bits [30:15] of the full product.
    function automatic logic signed [SAMP_W-1:0] q15_term(input logic signed [PROD_W-1:0] p);
        q15_term = p[QSHIFT+SAMP_W-1:QSHIFT];
    endfunction

endpackage

// ===== rtl/scc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 62
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scc_chest.sv =====
// Conjugate channel estimate H* = conj(R) * P over two register stages.
module scc_chest (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  scc_pkg::t_in_item i_item,
    output scc_pkg::t_side    o_side,
    output scc_pkg::t_cplx    o_h,
    output scc_pkg::t_cplx    o_s
);

    scc_pkg::t_side r_a_side;
    scc_pkg::t_cplx r_a_s;
    logic signed [scc_pkg::PROD_W-1:0] r_p_rr_pr, r_p_ri_pi, r_p_rr_pi, r_p_ri_pr;

    scc_pkg::t_side r_b_side;
    scc_pkg::t_cplx r_b_s;
    scc_pkg::t_cplx r_b_h;
    scc_pkg::t_cplx n_h;

    always_comb begin
        n_h.re = scc_pkg::q15_term(r_p_rr_pr) + scc_pkg::q15_term(r_p_ri_pi);
        n_h.im = scc_pkg::q15_term(r_p_rr_pi) - scc_pkg::q15_term(r_p_ri_pr);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_side.subcarrier    <= i_item.subcarrier;
            r_a_side.first_antenna <= i_item.first_antenna;
            r_a_s.re               <= i_item.sss_rx_re;
            r_a_s.im               <= i_item.sss_rx_im;
            r_p_rr_pr <= $signed(i_item.pss_rx_re) * $signed(i_item.pss_ref_re);
            r_p_ri_pi <= $signed(i_item.pss_rx_im) * $signed(i_item.pss_ref_im);
            r_p_rr_pi <= $signed(i_item.pss_rx_re) * $signed(i_item.pss_ref_im);
            r_p_ri_pr <= $signed(i_item.pss_rx_im) * $signed(i_item.pss_ref_re);

            r_b_side.subcarrier    <= r_a_side.subcarrier;
            r_b_side.first_antenna <= r_a_side.first_antenna;
            r_b_s                  <= r_a_s;
            r_b_h                  <= n_h;
        end
        if (!i_rst_n) begin
            r_a_side.valid <= 1'b0;
            r_b_side.valid <= 1'b0;
        end else if (i_adv) begin
            r_a_side.valid <= i_valid;
            r_b_side.valid <= r_a_side.valid;
        end
    end

    assign o_side = r_b_side;
    assign o_h    = r_b_h;
    assign o_s    = r_b_s;

endmodule

// ===== rtl/scc_comp.sv =====
// Compensation C = H* * S over two register stages.
module scc_comp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  scc_pkg::t_side i_side,
    input  scc_pkg::t_cplx i_h,
    input  scc_pkg::t_cplx i_s,
    output scc_pkg::t_side o_side,
    output scc_pkg::t_cplx o_c
);

    scc_pkg::t_side r_c_side;
    logic signed [scc_pkg::PROD_W-1:0] r_p_hr_sr, r_p_hi_si, r_p_hr_si, r_p_hi_sr;

    scc_pkg::t_side r_d_side;
    scc_pkg::t_cplx r_d_c;
    scc_pkg::t_cplx n_c;

    always_comb begin
        n_c.re = scc_pkg::q15_term(r_p_hr_sr) - scc_pkg::q15_term(r_p_hi_si);
        n_c.im = scc_pkg::q15_term(r_p_hr_si) + scc_pkg::q15_term(r_p_hi_sr);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_side.subcarrier    <= i_side.subcarrier;
            r_c_side.first_antenna <= i_side.first_antenna;
            r_p_hr_sr <= $signed(i_h.re) * $signed(i_s.re);
            r_p_hi_si <= $signed(i_h.im) * $signed(i_s.im);
            r_p_hr_si <= $signed(i_h.re) * $signed(i_s.im);
            r_p_hi_sr <= $signed(i_h.im) * $signed(i_s.re);

            r_d_side.subcarrier    <= r_c_side.subcarrier;
            r_d_side.first_antenna <= r_c_side.first_antenna;
            r_d_c                  <= n_c;
        end
        if (!i_rst_n) begin
            r_c_side.valid <= 1'b0;
            r_d_side.valid <= 1'b0;
        end else if (i_adv) begin
            r_c_side.valid <= i_side.valid;
            r_d_side.valid <= r_c_side.valid;
        end
    end

    assign o_side = r_d_side;
    assign o_c    = r_d_c;

endmodule

// ===== rtl/scc_mrc.sv =====
// Per-subcarrier combining store: read, forward, add and write back, then output register.
module scc_mrc #(
    parameter int NUM_SUBCARRIERS = 62
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  scc_pkg::t_side     i_side,
    input  scc_pkg::t_cplx     i_c,
    output logic               o_valid,
    output scc_pkg::t_out_item o_item
);

    localparam int AW = (NUM_SUBCARRIERS > 1) ? $clog2(NUM_SUBCARRIERS) : 1;
    localparam int DW = 2 * scc_pkg::SAMP_W;

    scc_pkg::t_side r_e_side;
    scc_pkg::t_cplx r_e_c;
    logic           r_byp_hit;
    scc_pkg::t_cplx r_byp_data;

    logic               r_o_valid;
    scc_pkg::t_out_item r_o_item;

    logic [AW-1:0]  w_raddr;
    logic [AW-1:0]  w_waddr;
    logic [DW-1:0]  w_rdata;
    logic           w_we;
    logic           w_e_in_range;
    scc_pkg::t_cplx w_old;
    scc_pkg::t_cplx w_new;

    assign w_raddr      = AW'(i_side.subcarrier);
    assign w_waddr      = AW'(r_e_side.subcarrier);
    assign w_e_in_range = 8'(r_e_side.subcarrier) < 8'(NUM_SUBCARRIERS);
    assign w_we         = i_adv && r_e_side.valid && w_e_in_range;

    always_comb begin
        w_old = r_byp_hit ? r_byp_data : scc_pkg::t_cplx'(w_rdata);
        if (r_e_side.first_antenna || !w_e_in_range) begin
            w_new = r_e_c;
        end else begin
            w_new.re = w_old.re + r_e_c.re;
            w_new.im = w_old.im + r_e_c.im;
        end
    end

    scc_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_SUBCARRIERS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (DW'(w_new)),
        .i_re    (i_adv),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e_side.subcarrier    <= i_side.subcarrier;
            r_e_side.first_antenna <= i_side.first_antenna;
            r_e_c                  <= i_c;
            r_byp_data             <= w_new;
            r_o_item.subcarrier_out <= r_e_side.subcarrier;
            r_o_item.comp_re        <= w_new.re;
            r_o_item.comp_im        <= w_new.im;
        end
        if (!i_rst_n) begin
            r_e_side.valid <= 1'b0;
            r_o_valid      <= 1'b0;
            r_byp_hit      <= 1'b0;
        end else if (i_adv) begin
            r_e_side.valid <= i_side.valid;
            r_o_valid      <= r_e_side.valid;
            // The store returns the old entry when it is written on the same edge.
            r_byp_hit      <= w_we && (w_waddr == w_raddr);
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

    a_write_only_valid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_e_side.valid && i_adv && w_e_in_range))
        else $error("store written without a valid in-range beat");

    a_beat_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_e_side.valid) |=>
            (r_o_valid && r_o_item.subcarrier_out == $past(r_e_side.subcarrier)))
        else $error("beat lost or index changed at output stage");

    a_first_antenna_overwrites: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_e_side.valid && r_e_side.first_antenna) |=>
            (r_o_item.comp_re == $past(r_e_c.re) && r_o_item.comp_im == $past(r_e_c.im)))
        else $error("first-antenna beat did not pass the compensated sample");

endmodule

// ===== rtl/sync_channel_compensate_mrc.sv =====
// Sync channel compensation with maximum-ratio combining across receive antennas.
//
// Input channel (i_valid, o_stall, i_item): one subcarrier beat carrying the
// received primary sample, its reference value and the received secondary sample.
// Output channel (o_valid, i_stall, o_item): the combined compensated secondary
// sample held so far for that subcarrier, one result beat for every input beat.
// Send all subcarriers of the first antenna with first_antenna set; later antennas
// add into the per-subcarrier store. Out-of-range indices bypass the store.
// Pipeline from input beat to result beat: estimate multiply and sum, compensation
// multiply and sum, store read, combine into the output register.
// Throughput: one beat per cycle while the receiver does not stall, paced by the
// pipelined complex multipliers and a store with one write and one read port;
// same-index beats back to back are forwarded around the store.
// Reset clears all valid bits; store contents stay undefined until written.
// While the receiver stalls with a result pending, the whole pipeline holds and
// o_stall is raised; an empty output register lets the pipeline keep moving.
module sync_channel_compensate_mrc #(
    parameter int NUM_SUBCARRIERS = 62
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  scc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output scc_pkg::t_out_item o_item
);

    logic           w_adv;
    scc_pkg::t_side w_est_side;
    scc_pkg::t_cplx w_est_h;
    scc_pkg::t_cplx w_est_s;
    scc_pkg::t_side w_cmp_side;
    scc_pkg::t_cplx w_cmp_c;

    // Advance everything when the output register is empty or being taken.
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    scc_chest u_chest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_side  (w_est_side),
        .o_h     (w_est_h),
        .o_s     (w_est_s)
    );

    scc_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_side  (w_est_side),
        .i_h     (w_est_h),
        .i_s     (w_est_s),
        .o_side  (w_cmp_side),
        .o_c     (w_cmp_c)
    );

    scc_mrc #(
        .NUM_SUBCARRIERS (NUM_SUBCARRIERS)
    ) u_mrc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_side  (w_cmp_side),
        .i_c     (w_cmp_c),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ===== dv/tb_sync_channel_compensate_mrc.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sync channel compensation with antenna combining.
module tb_sync_channel_compensate_mrc;

    localparam int SC_W       = scc_pkg::SC_W;
    localparam int SAMP_W     = scc_pkg::SAMP_W;
    localparam int QSHIFT     = scc_pkg::QSHIFT;
    localparam int NUM_SC     = 62;
    localparam int SC_MAX     = (1 << SC_W) - 1;
    localparam int N_ITEMS    = 1250;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYC  = 24;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;
    typedef enum {NOISE_ANY, NOISE_OUT_OF_RANGE, NOISE_REPEAT} t_noise;

    typedef struct {
        scc_pkg::t_in_item  item;
        bit                 typed;
        scc_pkg::t_out_item want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    scc_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_stall;
    scc_pkg::t_out_item o_item;

    // per-subcarrier combined value, as the block should hold it
    logic signed [SAMP_W-1:0] mrc_re [NUM_SC];
    logic signed [SAMP_W-1:0] mrc_im [NUM_SC];
    bit                 sc_written [NUM_SC];
    scc_pkg::t_out_item combined_q [$];
    t_dir_row           dir_rows [$];
    int                 n_mismatch = 0;
    int                 n_sent     = 0;
    int                 burst_left = 0;
    int                 idle_cyc   = 0;

    sync_channel_compensate_mrc #(.NUM_SUBCARRIERS(NUM_SC)) dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // floor(a*b / 2^15)
    function automatic int q15_mul(input logic signed [SAMP_W-1:0] a,
                                   input logic signed [SAMP_W-1:0] b);
        int prod;
        prod = a * b;
        return prod >>> QSHIFT;
    endfunction

    // H* = conj(R) * P, then C = H* * S, each sum wrapped to 16 bits
    function automatic scc_pkg::t_cplx compensate(input scc_pkg::t_in_item it);
        int                       acc;
        logic signed [SAMP_W-1:0] h_re;
        logic signed [SAMP_W-1:0] h_im;
        scc_pkg::t_cplx           c;
        acc  = q15_mul(it.pss_rx_re, it.pss_ref_re) + q15_mul(it.pss_rx_im, it.pss_ref_im);
        h_re = acc[SAMP_W-1:0];
        acc  = q15_mul(it.pss_rx_re, it.pss_ref_im) - q15_mul(it.pss_rx_im, it.pss_ref_re);
        h_im = acc[SAMP_W-1:0];
        acc  = q15_mul(h_re, it.sss_rx_re) - q15_mul(h_im, it.sss_rx_im);
        c.re = acc[SAMP_W-1:0];
        acc  = q15_mul(h_re, it.sss_rx_im) + q15_mul(h_im, it.sss_rx_re);
        c.im = acc[SAMP_W-1:0];
        return c;
    endfunction

    function automatic scc_pkg::t_out_item combine_predict(input scc_pkg::t_in_item it);
        scc_pkg::t_cplx     c;
        scc_pkg::t_out_item r;
        c = compensate(it);
        r.subcarrier_out = it.subcarrier;
        r.comp_re        = c.re;
        r.comp_im        = c.im;
        if (it.subcarrier < NUM_SC) begin
            if (it.first_antenna) begin
                mrc_re[it.subcarrier] = c.re;
                mrc_im[it.subcarrier] = c.im;
            end else begin
                mrc_re[it.subcarrier] = mrc_re[it.subcarrier] + c.re;
                mrc_im[it.subcarrier] = mrc_im[it.subcarrier] + c.im;
            end
            r.comp_re = mrc_re[it.subcarrier];
            r.comp_im = mrc_im[it.subcarrier];
        end
        return r;
    endfunction

    function automatic logic signed [SAMP_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return SAMP_W'($urandom);
        endcase
    endfunction

    function automatic scc_pkg::t_in_item rand_item(input int sc, input bit first);
        scc_pkg::t_in_item it;
        it.subcarrier    = SC_W'(sc);
        it.first_antenna = first;
        it.pss_rx_re     = rand_sample();
        it.pss_rx_im     = rand_sample();
        it.pss_ref_re    = rand_sample();
        it.pss_ref_im    = rand_sample();
        it.sss_rx_re     = rand_sample();
        it.sss_rx_im     = rand_sample();
        return it;
    endfunction

    function automatic void add_row(input int sc, input bit first, input int rr, input int ri,
                                    input int pr, input int pi, input int sr, input int si,
                                    input bit typed, input int w_re, input int w_im);
        t_dir_row row;
        row.item.subcarrier     = SC_W'(sc);
        row.item.first_antenna  = first;
        row.item.pss_rx_re      = SAMP_W'(rr);
        row.item.pss_rx_im      = SAMP_W'(ri);
        row.item.pss_ref_re     = SAMP_W'(pr);
        row.item.pss_ref_im     = SAMP_W'(pi);
        row.item.sss_rx_re      = SAMP_W'(sr);
        row.item.sss_rx_im      = SAMP_W'(si);
        row.typed               = typed;
        row.want.subcarrier_out = SC_W'(sc);
        row.want.comp_re        = SAMP_W'(w_re);
        row.want.comp_im        = SAMP_W'(w_im);
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_mismatch++;
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic push_beat(input scc_pkg::t_in_item it, input bit typed,
                             input scc_pkg::t_out_item typed_want);
        scc_pkg::t_out_item want;
        if (it.subcarrier < NUM_SC) begin
            // never accumulate into an entry that holds no value yet
            if (!sc_written[it.subcarrier]) it.first_antenna = 1'b1;
            sc_written[it.subcarrier] = 1'b1;
        end
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = combine_predict(it);
        combined_q.push_back(typed ? typed_want : want);
        n_sent++;
    endtask

    task automatic send_noise(input int cur);
        case (t_noise'($urandom_range(0, 2)))
            NOISE_ANY:
                push_beat(rand_item($urandom_range(0, SC_MAX), $urandom_range(0, 1)), 1'b0, '0);
            NOISE_OUT_OF_RANGE:
                push_beat(rand_item($urandom_range(NUM_SC, SC_MAX), $urandom_range(0, 1)),
                          1'b0, '0);
            default: begin
                // back-to-back accumulates on one index
                repeat ($urandom_range(2, 4)) push_beat(rand_item(cur, 1'b0), 1'b0, '0);
            end
        endcase
    endtask

    initial begin
        t_stall_mode mode;
        int          span;
        i_stall <= 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= ((k % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        scc_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (combined_q.size() == 0) begin
                report_mismatch("result beat with nothing pending, subcarrier",
                                o_item.subcarrier_out, -1);
            end else begin
                want = combined_q.pop_front();
                if (o_item.subcarrier_out !== want.subcarrier_out)
                    report_mismatch("subcarrier_out", o_item.subcarrier_out,
                                    want.subcarrier_out);
                if (o_item.comp_re !== want.comp_re)
                    report_mismatch($sformatf("comp_re, subcarrier %0d", want.subcarrier_out),
                                    o_item.comp_re, want.comp_re);
                if (o_item.comp_im !== want.comp_im)
                    report_mismatch($sformatf("comp_im, subcarrier %0d", want.subcarrier_out),
                                    o_item.comp_im, want.comp_im);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("sync_channel_compensate_mrc: mismatch");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    initial begin
        int order [NUM_SC];
        int n_ant;
        int stop_at;
        int j;
        int tmp;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;

        // typed rows: after reset, extremes, wrap on accumulate, out-of-range bypass
        add_row(0,  1, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(0,  1, -32768, 0, -32768, 0, -32768, 0, 1, -32768, 0);
        add_row(0,  0, -32768, 0, -32768, 0, -32768, 0, 1, 0, 0);
        add_row(61, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(63, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_row(62, 1, -32768, 0, -32768, 0, -32768, 0, 1, -32768, 0);
        add_row(63, 0, -32768, 0, -32768, 0, -32768, 0, 1, -32768, 0);
        // predicted rows
        add_row(61, 1, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0);
        add_row(61, 0, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0);
        add_row(1,  1, 0, -32768, 0, -32768, 0, -32768, 0, 0, 0);
        add_row(1,  0, -32768, 32767, 32767, -32768, -32768, -32768, 0, 0, 0);
        add_row(1,  0, -1, -1, -1, -1, -1, -1, 0, 0, 0);
        add_row(42, 1, 1, -1, -32768, 32767, 32767, -1, 0, 0, 0);
        add_row(21, 1, 21845, -21846, 21845, -21846, 21845, -21846, 0, 0, 0);
        add_row(42, 0, -21846, 21845, 21845, -21846, -21846, 21845, 0, 0, 0);
        add_row(42, 0, 12345, -12345, 30000, -30000, -1, 1, 0, 0, 0);
        add_row(42, 0, 12345, -12345, 30000, -30000, -1, 1, 0, 0, 0);
        add_row(0,  1, 4660, -22136, 1000, -999, 32767, -32768, 0, 0, 0);
        add_row(62, 0, 777, -778, -32768, 32767, 256, -256, 0, 0, 0);
        add_row(63, 1, -32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) push_beat(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

        // antenna sets: a first-antenna sweep, then accumulating sweeps, with noise mixed in
        while (n_sent < N_ITEMS) begin
            n_ant = $urandom_range(1, 4);
            for (int a = 0; a < n_ant && n_sent < N_ITEMS; a++) begin
                foreach (order[k]) order[k] = k;
                if ($urandom_range(0, 1)) begin
                    for (int k = NUM_SC - 1; k > 0; k--) begin
                        j        = $urandom_range(0, k);
                        tmp      = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                end
                // cut a sweep short now and then
                stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, NUM_SC - 1) : NUM_SC;
                for (int k = 0; k < stop_at && n_sent < N_ITEMS; k++) begin
                    if ($urandom_range(0, 9) == 0) send_noise(order[k]);
                    push_beat(rand_item(order[k], a == 0), 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (combined_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("sync_channel_compensate_mrc: match");
        end else begin
            $display("sync_channel_compensate_mrc: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_chest.sv
rtl/scc_comp.sv
rtl/scc_mrc.sv
rtl/sync_channel_compensate_mrc.sv
dv/tb_sync_channel_compensate_mrc.sv
